// ===== rtl/core/ism_pkg.sv =====
// Shared types, codes and a helper function for the interval set merge block.
// No dependencies; every other file of the block but ism_if imports this package.
`timescale 1ns / 1ps
`default_nettype none

package ism_pkg;

	// Default number of span cells in the sorting chain.
	localparam int ISM_MAX_SPANS = 64;

	localparam int TIME_W = 64;

	// Input action codes.
	localparam logic [1:0] ACT_SPAN    = 2'd0;
	localparam logic [1:0] ACT_MISSING = 2'd1;
	localparam logic [1:0] ACT_EMPTY   = 2'd2;

	// Result kind codes.
	localparam logic [1:0] KIND_SPAN     = 2'd0;
	localparam logic [1:0] KIND_MISSING  = 2'd1;
	localparam logic [1:0] KIND_HOLE     = 2'd2;
	localparam logic [1:0] KIND_OVERFLOW = 2'd3;

	// One span as held by a cell or broadcast along the chain.
	typedef struct packed {
		logic [TIME_W-1:0] span_start;
		logic [TIME_W-1:0] span_end;
	} span_t;

	// Contents of one cell of the chain.
	typedef struct packed {
		logic  valid;
		span_t span;
	} cell_t;

	// Commands from the controller to every cell.
	typedef struct packed {
		logic insert;
		logic pop;
		logic clear;
	} ism_cmd_t;

	// Chain status seen by the controller.
	typedef struct packed {
		logic  full;
		cell_t head;
	} ism_stat_t;

	// Controller states.
	typedef enum logic [1:0] {
		ST_LOAD,
		ST_MERGE,
		ST_FLUSH,
		ST_STATUS
	} ism_state_t;

	// Order by start, then by end, both as signed times.
	function automatic logic key_less(input span_t a, input span_t b);
		logic lt_start;
		logic eq_start;
		logic lt_end;
		lt_start = $signed(a.span_start) < $signed(b.span_start);
		eq_start = a.span_start == b.span_start;
		lt_end   = $signed(a.span_end) < $signed(b.span_end);
		return lt_start || (eq_start && lt_end);
	endfunction

endpackage

`default_nettype wire

// ===== rtl/core/ism_if.sv =====
// Stream interfaces for the input items and the result items.
// Each carries valid, ready and the payload of one beat.
`timescale 1ns / 1ps
`default_nettype none

interface ism_in_if;
	logic               valid;
	logic               ready;
	logic [1:0]         action;
	logic signed [63:0] span_start;
	logic signed [63:0] span_end;
	logic               set_last;

	modport source (output valid, action, span_start, span_end, set_last, input ready);
	modport sink   (input valid, action, span_start, span_end, set_last, output ready);
endinterface

interface ism_out_if;
	logic               valid;
	logic               ready;
	logic [1:0]         result_kind;
	logic signed [63:0] merged_start;
	logic signed [63:0] merged_end;
	logic               run_last;

	modport source (output valid, result_kind, merged_start, merged_end, run_last, input ready);
	modport sink   (input valid, result_kind, merged_start, merged_end, run_last, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/ism_cell.sv =====
// One cell of the sorted span chain: holds one span and a valid bit.
// Depends on ism_pkg for the cell, span and command types.
`timescale 1ns / 1ps
`default_nettype none

module ism_cell (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire ism_pkg::ism_cmd_t cmd,
	input  wire ism_pkg::span_t    key,
	input  wire ism_pkg::cell_t    prev_cell,
	input  wire logic              prev_less,
	input  wire ism_pkg::cell_t    next_cell,
	output ism_pkg::cell_t         held,
	output logic                   less
);
	import ism_pkg::*;

	logic  valid_q;
	span_t span_q;
	logic  take_prev;
	logic  take_key;

	// The new span sorts before this cell's span.
	assign less = valid_q && key_less(key, span_q);

	// On insert, cells after the insertion point shift up by one and the
	// first cell that the key precedes, or the first empty cell, takes the key.
	assign take_prev = cmd.insert && prev_less;
	assign take_key  = cmd.insert && !prev_less && prev_cell.valid && (less || !valid_q);

	// Valid bit.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (cmd.clear) begin
			valid_q <= 1'b0;
		end else if (cmd.pop) begin
			valid_q <= next_cell.valid;
		end else if (take_prev || take_key) begin
			valid_q <= 1'b1;
		end
	end

	// Span payload.
	always_ff @(posedge clk) begin
		if (cmd.pop) begin
			span_q <= next_cell.span;
		end else if (take_prev) begin
			span_q <= prev_cell.span;
		end else if (take_key) begin
			span_q <= key;
		end
	end

	assign held = '{valid: valid_q, span: span_q};

endmodule

`default_nettype wire

// ===== rtl/core/ism_ctrl.sv =====
// Set controller: tracks the set flags, drains the chain through the merge
// register and drives the result register. Depends on ism_pkg and ism_if.
`timescale 1ns / 1ps
`default_nettype none

module ism_ctrl (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               cfg_we,
	input  wire logic               cfg_wdata,
	ism_in_if.sink                  span_in,
	ism_out_if.source               result_out,
	input  wire ism_pkg::ism_stat_t stat,
	output ism_pkg::ism_cmd_t       cmd
);
	import ism_pkg::*;

	ism_state_t state_q;
	ism_state_t state_d;

	logic        drop_missing_q;
	logic        saw_missing_q;
	logic        saw_present_q;
	logic        overflowed_q;
	logic [1:0]  status_kind_q;

	logic        cur_valid_q;
	logic [63:0] cur_start_q;
	logic [63:0] cur_end_q;

	logic        out_valid_q;
	logic [1:0]  out_kind_q;
	logic [63:0] out_start_q;
	logic [63:0] out_end_q;
	logic        out_last_q;

	logic        in_acc;
	logic        last_acc;
	logic        is_span;
	logic        missing_d;
	logic        present_d;
	logic        overflow_d;
	logic        spans_d;
	logic        go_merge;
	logic [1:0]  status_kind_d;
	logic        out_free;
	logic        overlap;
	logic        take_head;
	logic        emit_mid;
	logic        emit_last;
	logic        emit_status;
	logic        out_load;

	assign in_acc   = span_in.valid && span_in.ready;
	assign last_acc = in_acc && span_in.set_last;
	assign is_span  = span_in.action == ACT_SPAN;
	assign out_free = !out_valid_q || result_out.ready;
	assign overlap  = $signed(stat.head.span.span_start) <= $signed(cur_end_q);

	// Flags of the set including the beat now taken.
	always_comb begin
		missing_d  = saw_missing_q || (span_in.action == ACT_MISSING);
		present_d  = saw_present_q || is_span || (span_in.action == ACT_EMPTY);
		overflow_d = overflowed_q || (is_span && stat.full);
		spans_d    = stat.head.valid || is_span;
		go_merge   = 1'b0;
		priority if ((missing_d && !drop_missing_q) || !present_d) begin
			status_kind_d = KIND_MISSING;
		end else if (overflow_d) begin
			status_kind_d = KIND_OVERFLOW;
		end else if (!spans_d) begin
			status_kind_d = KIND_HOLE;
		end else begin
			status_kind_d = KIND_SPAN;
			go_merge      = 1'b1;
		end
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_LOAD: begin
				if (last_acc) begin
					state_d = go_merge ? ST_MERGE : ST_STATUS;
				end
			end
			ST_MERGE: begin
				if (!stat.head.valid) begin
					state_d = ST_FLUSH;
				end
			end
			ST_FLUSH: begin
				if (out_free) begin
					state_d = ST_LOAD;
				end
			end
			ST_STATUS: begin
				if (out_free) begin
					state_d = ST_LOAD;
				end
			end
			default: begin
				state_d = ST_LOAD;
			end
		endcase
	end

	// State outputs: input ready, chain commands and result loads.
	always_comb begin
		span_in.ready = 1'b0;
		take_head     = 1'b0;
		emit_mid      = 1'b0;
		emit_last     = 1'b0;
		emit_status   = 1'b0;
		unique case (state_q)
			ST_LOAD: begin
				span_in.ready = 1'b1;
			end
			ST_MERGE: begin
				take_head = stat.head.valid && (!cur_valid_q || overlap || out_free);
				emit_mid  = stat.head.valid && cur_valid_q && !overlap && out_free;
			end
			ST_FLUSH: begin
				emit_last = out_free;
			end
			ST_STATUS: begin
				emit_status = out_free;
			end
			default: begin
				span_in.ready = 1'b0;
			end
		endcase
		cmd.insert = in_acc && is_span && !stat.full;
		cmd.clear  = last_acc && !go_merge;
		cmd.pop    = take_head;
	end

	assign out_load = emit_mid || emit_last || emit_status;

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
		end else begin
			state_q <= state_d;
		end
	end

	// Configuration register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			drop_missing_q <= 1'b0;
		end else if (cfg_we) begin
			drop_missing_q <= cfg_wdata;
		end
	end

	// Set flags, cleared at the last beat of a set.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			saw_missing_q <= 1'b0;
			saw_present_q <= 1'b0;
			overflowed_q  <= 1'b0;
		end else if (last_acc) begin
			saw_missing_q <= 1'b0;
			saw_present_q <= 1'b0;
			overflowed_q  <= 1'b0;
		end else if (in_acc) begin
			saw_missing_q <= missing_d;
			saw_present_q <= present_d;
			overflowed_q  <= overflow_d;
		end
	end

	// Verdict of the finished set.
	always_ff @(posedge clk) begin
		if (last_acc) begin
			status_kind_q <= status_kind_d;
		end
	end

	// Merge register: valid bit.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_valid_q <= 1'b0;
		end else if (take_head) begin
			cur_valid_q <= 1'b1;
		end else if (emit_last) begin
			cur_valid_q <= 1'b0;
		end
	end

	// Merge register: a new run starts or the current run grows.
	always_ff @(posedge clk) begin
		if (take_head) begin
			if (!cur_valid_q || !overlap) begin
				cur_start_q <= stat.head.span.span_start;
				cur_end_q   <= stat.head.span.span_end;
			end else if ($signed(stat.head.span.span_end) > $signed(cur_end_q)) begin
				cur_end_q <= stat.head.span.span_end;
			end
		end
	end

	// Result register valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (result_out.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Result register payload.
	always_ff @(posedge clk) begin
		if (emit_status) begin
			out_kind_q  <= status_kind_q;
			out_start_q <= '0;
			out_end_q   <= '0;
			out_last_q  <= 1'b1;
		end else if (emit_mid || emit_last) begin
			out_kind_q  <= KIND_SPAN;
			out_start_q <= cur_start_q;
			out_end_q   <= cur_end_q;
			out_last_q  <= emit_last;
		end
	end

	assign result_out.valid        = out_valid_q;
	assign result_out.result_kind  = out_kind_q;
	assign result_out.merged_start = out_start_q;
	assign result_out.merged_end   = out_end_q;
	assign result_out.run_last     = out_last_q;

endmodule

`default_nettype wire

// ===== rtl/core/interval_set_merge.sv =====
// Interval set merge: takes one input beat per cycle while a set loads. After the last
// beat, the controller passes through ST_STATUS to load a status result into the result
// register, and the input opens again when that result becomes valid. A set of stored
// spans drains one cell per cycle unless a result beat is stalled; its last merged span
// is loaded in ST_FLUSH and the input opens again with it. Reset clears all cell valid
// bits, the set flags and drop_missing at once. Depends on ism_pkg, ism_if, ism_cell, ism_ctrl.
`timescale 1ns / 1ps
`default_nettype none

module interval_set_merge #(
	parameter int MAX_SPANS = ism_pkg::ISM_MAX_SPANS
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic cfg_we,
	input  wire logic cfg_wdata,
	ism_in_if.sink    span_in,
	ism_out_if.source result_out
);
	import ism_pkg::*;

	cell_t     cells   [MAX_SPANS];
	logic      less_w  [MAX_SPANS];
	cell_t     edge_prev;
	cell_t     edge_next;
	span_t     key;
	ism_cmd_t  cmd;
	ism_stat_t stat;

	// Sentinels at both ends of the chain.
	assign edge_prev = '{valid: 1'b1, span: '0};
	assign edge_next = '{valid: 1'b0, span: '0};

	assign key.span_start = span_in.span_start;
	assign key.span_end   = span_in.span_end;

	// Chain of sorted cells, lowest key in cell zero.
	for (genvar i = 0; i < MAX_SPANS; i++) begin : g_cell
		cell_t c_prev;
		cell_t c_next;
		logic  c_prev_less;
		if (i == 0) begin : g_first
			assign c_prev      = edge_prev;
			assign c_prev_less = 1'b0;
		end else begin : g_mid
			assign c_prev      = cells[i-1];
			assign c_prev_less = less_w[i-1];
		end
		if (i == MAX_SPANS - 1) begin : g_end
			assign c_next = edge_next;
		end else begin : g_inner
			assign c_next = cells[i+1];
		end
		ism_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.cmd       (cmd),
			.key       (key),
			.prev_cell (c_prev),
			.prev_less (c_prev_less),
			.next_cell (c_next),
			.held      (cells[i]),
			.less      (less_w[i])
		);
	end

	assign stat.full = cells[MAX_SPANS-1].valid;
	assign stat.head = cells[0];

	// Set control, merge and result register.
	ism_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.span_in    (span_in),
		.result_out (result_out),
		.stat       (stat),
		.cmd        (cmd)
	);

endmodule

`default_nettype wire

// ===== rtl/core/ism_checker.sv =====
// Port-level checks for interval_set_merge, attached by the bind below.
// Depends on ism_pkg for the result kind codes.
`timescale 1ns / 1ps
`default_nettype none

module ism_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        in_valid,
	input wire logic        in_ready,
	input wire logic        in_last,
	input wire logic        out_valid,
	input wire logic        out_ready,
	input wire logic [1:0]  out_kind,
	input wire logic [63:0] out_start,
	input wire logic [63:0] out_end,
	input wire logic        out_last
);
	import ism_pkg::*;

	logic        out_acc;
	logic        pend_q;
	logic [63:0] prev_end_q;

	assign out_acc = out_valid && out_ready;

	// Remember whether the last result beat was a span with more to follow.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= 1'b0;
		end else if (out_acc) begin
			pend_q <= (out_kind == KIND_SPAN) && !out_last;
		end
	end

	always_ff @(posedge clk) begin
		if (out_acc) begin
			prev_end_q <= out_end;
		end
	end

	// A status result stands alone, closes its set and carries zero times.
	a_status_alone: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_kind != KIND_SPAN) |-> (out_last && out_start == '0 && out_end == '0))
		else $error("status result without run_last or with nonzero times");

	// Within a set, merged spans come out in order with a gap between them.
	a_span_order: assert property (@(posedge clk) disable iff (!arst_n)
		(out_acc && pend_q) |-> (out_kind == KIND_SPAN && $signed(out_start) > $signed(prev_end_q)))
		else $error("merged span does not follow the previous one with a gap");

	// The input closes after the last beat of a set.
	a_close_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready && in_last) |=> !in_ready)
		else $error("input still open after the last beat of a set");

	// A stalled result beat holds.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> (out_valid && $stable(out_kind) && $stable(out_start)
			&& $stable(out_end) && $stable(out_last)))
		else $error("stalled result beat changed");

endmodule

bind interval_set_merge ism_checker u_ism_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (span_in.valid),
	.in_ready  (span_in.ready),
	.in_last   (span_in.set_last),
	.out_valid (result_out.valid),
	.out_ready (result_out.ready),
	.out_kind  (result_out.result_kind),
	.out_start (result_out.merged_start),
	.out_end   (result_out.merged_end),
	.out_last  (result_out.run_last)
);

`default_nettype wire

// ===== tb/tb_interval_set_merge.sv =====
// Self-checking testbench for interval_set_merge: streams sets of spans and
// status markers in, and checks every merged span or status result it gets back.
// Depends on ism_pkg, ism_in_if, ism_out_if and the interval_set_merge RTL.
`timescale 1ns / 1ps

module tb_interval_set_merge;
	import ism_pkg::*;

	localparam int SPAN_CAP = ism_pkg::ISM_MAX_SPANS;
	// Code 3 on the action field has no meaning and must be ignored.
	localparam logic [1:0] ACT_UNUSED = 2'd3;
	localparam int IDLE_PCT = 28;
	localparam int SETTLE_CYCLES = SPAN_CAP + 8;
	localparam int HOLD_AT_RESULT = 20;
	localparam int HOLD_CYCLES = 400;
	localparam int CYCLE_LIMIT = 300000;
	localparam logic signed [63:0] T_MIN = 64'sh8000_0000_0000_0000;
	localparam logic signed [63:0] T_MAX = 64'sh7fff_ffff_ffff_ffff;

	typedef struct {
		logic [1:0]         action;
		logic signed [63:0] lo;
		logic signed [63:0] hi;
		logic               last;
	} span_item_t;

	typedef struct {
		logic [1:0]         kind;
		logic signed [63:0] lo;
		logic signed [63:0] hi;
		logic               last;
	} span_result_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic cfg_wdata;

	ism_in_if  span_in_bus ();
	ism_out_if result_bus ();

	interval_set_merge #(
		.MAX_SPANS(SPAN_CAP)
	) dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.span_in   (span_in_bus),
		.result_out(result_bus)
	);

	// Items waiting to be sent and the merged results still owed by the block.
	span_item_t   pending_items[$];
	span_result_t expected_spans[$];
	span_item_t   cur_item;

	// Shadow of the block: drop_missing copy, sorted span store and set flags.
	logic               drop_copy;
	logic signed [63:0] sort_lo[SPAN_CAP];
	logic signed [63:0] sort_hi[SPAN_CAP];
	int                 n_stored;
	bit                 got_missing;
	bit                 got_present;
	bit                 got_overflow;

	bit          quiet;
	int          beats_in;
	int          results_seen;
	int          sets_closed;
	int          mismatches;
	int          kind_count[4];
	int          hold_left;
	bit          hold_done;
	int unsigned cycles = 0;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Fold one accepted beat into the shadow state; at the end of a set, queue
	// the results the block must produce.
	task automatic fold_beat(input span_item_t b);
		int                 pos;
		int                 i;
		logic signed [63:0] cur_lo;
		logic signed [63:0] cur_hi;
		span_result_t       r;
		bit                 is_status;
		case (b.action)
			ACT_SPAN: begin
				got_present = 1'b1;
				if (n_stored >= SPAN_CAP) begin
					got_overflow = 1'b1;
				end else begin
					// Insertion sort by start, then by end.
					pos = n_stored;
					while (pos > 0 && (b.lo < sort_lo[pos-1] ||
						(b.lo == sort_lo[pos-1] && b.hi < sort_hi[pos-1]))) begin
						sort_lo[pos] = sort_lo[pos-1];
						sort_hi[pos] = sort_hi[pos-1];
						pos--;
					end
					sort_lo[pos] = b.lo;
					sort_hi[pos] = b.hi;
					n_stored++;
				end
			end
			ACT_MISSING: got_missing = 1'b1;
			ACT_EMPTY:   got_present = 1'b1;
			default: ;
		endcase
		if (b.last) begin
			is_status = 1'b1;
			r.lo = '0;
			r.hi = '0;
			r.last = 1'b1;
			if ((got_missing && !drop_copy) || !got_present)
				r.kind = KIND_MISSING;
			else if (got_overflow)
				r.kind = KIND_OVERFLOW;
			else if (n_stored == 0)
				r.kind = KIND_HOLE;
			else
				is_status = 1'b0;
			if (is_status) begin
				expected_spans.push_back(r);
				kind_count[r.kind]++;
			end else begin
				// Join sorted spans that overlap or touch the running end.
				cur_lo = sort_lo[0];
				cur_hi = sort_hi[0];
				r.kind = KIND_SPAN;
				r.last = 1'b0;
				for (i = 1; i < n_stored; i++) begin
					if (sort_lo[i] <= cur_hi) begin
						if (sort_hi[i] > cur_hi)
							cur_hi = sort_hi[i];
					end else begin
						r.lo = cur_lo;
						r.hi = cur_hi;
						expected_spans.push_back(r);
						kind_count[KIND_SPAN]++;
						cur_lo = sort_lo[i];
						cur_hi = sort_hi[i];
					end
				end
				r.lo = cur_lo;
				r.hi = cur_hi;
				r.last = 1'b1;
				expected_spans.push_back(r);
				kind_count[KIND_SPAN]++;
			end
			sets_closed++;
			n_stored = 0;
			got_missing = 1'b0;
			got_present = 1'b0;
			got_overflow = 1'b0;
		end
	endtask

	// Driver: holds a beat until it is taken, then offers the next one or idles.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			span_in_bus.valid <= 1'b0;
		end else begin
			if (span_in_bus.valid && span_in_bus.ready) begin
				fold_beat(cur_item);
				beats_in++;
			end
			if (!span_in_bus.valid || span_in_bus.ready) begin
				if (pending_items.size() > 0 && (quiet || $urandom_range(0, 99) >= IDLE_PCT)) begin
					cur_item = pending_items.pop_front();
					span_in_bus.valid      <= 1'b1;
					span_in_bus.action     <= cur_item.action;
					span_in_bus.span_start <= cur_item.lo;
					span_in_bus.span_end   <= cur_item.hi;
					span_in_bus.set_last   <= cur_item.last;
				end else begin
					span_in_bus.valid <= 1'b0;
				end
			end
		end
	end

	// Long hold-off of the receiver, counted in cycles once enough results are in.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_left <= 0;
			hold_done <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
		end else if (!hold_done && results_seen >= HOLD_AT_RESULT) begin
			hold_done <= 1'b1;
			hold_left <= HOLD_CYCLES;
		end
	end

	// Monitor: checks each result beat against the oldest expectation and
	// throttles ready, keeping it low during the long hold-off.
	always @(posedge clk or negedge arst_n) begin
		span_result_t want;
		if (!arst_n) begin
			result_bus.ready <= 1'b0;
		end else begin
			if (result_bus.valid && result_bus.ready) begin
				results_seen++;
				if (expected_spans.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected result beat: kind %0d [%0d, %0d] last %0d",
							result_bus.result_kind, result_bus.merged_start,
							result_bus.merged_end, result_bus.run_last);
				end else begin
					want = expected_spans.pop_front();
					if (result_bus.result_kind !== want.kind ||
						result_bus.merged_start !== want.lo ||
						result_bus.merged_end !== want.hi ||
						result_bus.run_last !== want.last) begin
						mismatches++;
						if (mismatches <= 10)
							$display({"result %0d mismatch: expected kind %0d [%0d, %0d] ",
								"last %0d, got kind %0d [%0d, %0d] last %0d"},
								results_seen, want.kind, want.lo, want.hi, want.last,
								result_bus.result_kind, result_bus.merged_start,
								result_bus.merged_end, result_bus.run_last);
					end
				end
			end
			if (hold_left > 0) begin
				result_bus.ready <= 1'b0;
			end else begin
				result_bus.ready <= quiet || ($urandom_range(0, 99) >= IDLE_PCT);
			end
		end
	end

	// Watchdog on the total run length.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	task automatic add_beat(input logic [1:0] act, input logic signed [63:0] lo,
		input logic signed [63:0] hi, input logic last);
		span_item_t it;
		it.action = act;
		it.lo = lo;
		it.hi = hi;
		it.last = last;
		pending_items.push_back(it);
	endtask

	// A set of mostly spans clustered around one base so that many overlap.
	task automatic random_set(input int n_items);
		logic signed [63:0] base;
		logic signed [63:0] lo;
		logic signed [63:0] hi;
		logic [1:0]         act;
		int                 pick;
		int                 i;
		if ($urandom_range(0, 3) == 0) begin
			base = {$urandom, $urandom};
		end else begin
			base = $urandom_range(0, 60);
			base = base - 30;
		end
		for (i = 0; i < n_items; i++) begin
			pick = $urandom_range(0, 99);
			if (pick < 80)
				act = ACT_SPAN;
			else if (pick < 88)
				act = ACT_MISSING;
			else if (pick < 95)
				act = ACT_EMPTY;
			else
				act = ACT_UNUSED;
			if ($urandom_range(0, 9) == 0) begin
				lo = {$urandom, $urandom};
				hi = {$urandom, $urandom};
			end else begin
				lo = base + $urandom_range(0, 40);
				hi = lo + $urandom_range(0, 12);
				if ($urandom_range(0, 15) == 0)
					hi = lo - $urandom_range(1, 5);
			end
			add_beat(act, lo, hi, i == n_items - 1);
		end
	endtask

	// A set of short spans scattered over the full range, nearly all disjoint.
	task automatic wide_set(input int n_spans);
		logic signed [63:0] lo;
		int                 i;
		for (i = 0; i < n_spans; i++) begin
			lo = {$urandom, $urandom};
			add_beat(ACT_SPAN, lo, lo + $urandom_range(0, 1000), i == n_spans - 1);
		end
	endtask

	task automatic set_drop(input logic v);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		drop_copy = v;
	endtask

	// Wait until every beat is sent and every result is in, then let the
	// block finish any drain still under way.
	task automatic drain_phase();
		do
			@(negedge clk);
		while (pending_items.size() != 0 || span_in_bus.valid || expected_spans.size() != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	initial begin
		int n;
		int budget;
		int phase;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = 1'b0;
		span_in_bus.valid = 1'b0;
		span_in_bus.action = ACT_SPAN;
		span_in_bus.span_start = '0;
		span_in_bus.span_end = '0;
		span_in_bus.set_last = 1'b0;
		result_bus.ready = 1'b0;
		drop_copy = 1'b0;
		n_stored = 0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// Directed sets with missing elements kept.
		set_drop(1'b0);
		@(negedge clk);
		// One span covering the whole time range.
		add_beat(ACT_SPAN, T_MIN, T_MAX, 1'b1);
		// Touching spans join, a gap splits, and an inverted span stays as given.
		add_beat(ACT_SPAN, 64'sd11, 64'sd12, 1'b0);
		add_beat(ACT_SPAN, 64'sd5, 64'sd9, 1'b0);
		add_beat(ACT_SPAN, 64'sd20, 64'sd15, 1'b0);
		add_beat(ACT_SPAN, 64'sd0, 64'sd5, 1'b1);
		// A missing element turns the set into a missing result.
		add_beat(ACT_SPAN, -64'sd7, 64'sd3, 1'b0);
		add_beat(ACT_MISSING, 64'sd0, 64'sd0, 1'b1);
		// Present elements but no spans give a hole.
		add_beat(ACT_EMPTY, T_MAX, T_MIN, 1'b1);
		// Only missing elements.
		add_beat(ACT_MISSING, T_MIN, T_MAX, 1'b1);
		// The unused code alone leaves nothing present.
		add_beat(ACT_UNUSED, T_MAX, T_MAX, 1'b1);
		// The unused code is ignored, but its end-of-set mark still counts.
		add_beat(ACT_SPAN, -64'sd100, -64'sd90, 1'b0);
		add_beat(ACT_UNUSED, 64'sd1, 64'sd2, 1'b1);
		// Equal starts order by end, duplicates included.
		add_beat(ACT_SPAN, 64'sd3, 64'sd4, 1'b0);
		add_beat(ACT_SPAN, 64'sd3, 64'sd10, 1'b0);
		add_beat(ACT_SPAN, 64'sd3, 64'sd1, 1'b0);
		add_beat(ACT_SPAN, 64'sd3, 64'sd4, 1'b1);
		// Points at both ends of the range.
		add_beat(ACT_SPAN, T_MAX, T_MAX, 1'b0);
		add_beat(ACT_SPAN, T_MIN, T_MIN, 1'b1);
		// An empty element next to a span.
		add_beat(ACT_EMPTY, 64'sd0, 64'sd0, 1'b0);
		add_beat(ACT_SPAN, 64'sd42, 64'sd42, 1'b1);
		drain_phase();

		// Directed sets with missing elements dropped.
		set_drop(1'b1);
		@(negedge clk);
		add_beat(ACT_SPAN, 64'sd100, 64'sd110, 1'b0);
		add_beat(ACT_MISSING, 64'sd0, 64'sd0, 1'b0);
		add_beat(ACT_SPAN, 64'sd105, 64'sd120, 1'b1);
		add_beat(ACT_MISSING, 64'sd0, 64'sd0, 1'b1);
		add_beat(ACT_MISSING, 64'sd0, 64'sd0, 1'b0);
		add_beat(ACT_EMPTY, 64'sd0, 64'sd0, 1'b1);
		drain_phase();

		// Random phases alternate drop_missing; one fills the store exactly and
		// one overflows it while both sides run without idling.
		for (phase = 0; phase < 4; phase++) begin
			set_drop(phase[0]);
			@(negedge clk);
			if (phase == 2)
				quiet = 1'b1;
			budget = 16;
			while (budget > 0) begin
				n = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 24)
					: $urandom_range(1, 6);
				random_set(n);
				budget -= n;
			end
			if (phase == 1)
				wide_set(SPAN_CAP);
			if (phase == 2)
				wide_set(SPAN_CAP + 2);
			drain_phase();
			@(negedge clk);
			quiet = 1'b0;
		end

		$display({"Ran %0d input beats in %0d sets and checked %0d result beats ",
			"(%0d spans, %0d missing, %0d hole, %0d overflow)."},
			beats_in, sets_closed, results_seen, kind_count[KIND_SPAN],
			kind_count[KIND_MISSING], kind_count[KIND_HOLE], kind_count[KIND_OVERFLOW]);
		$display("drop_missing took both values; %0d mismatches, %0d results never arrived.",
			mismatches, expected_spans.size());
		if (mismatches == 0 && expected_spans.size() == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
